>>> design/rbs_pkg.sv
// ============================================================================
// rbs_pkg: shared types and float helpers for the ray/box slab test
// Request and result structs, pipeline stage records, single-precision
// align/normalize/round helpers, restoring divide step and IEEE compare.
// ============================================================================
package rbs_pkg;

  localparam int DIV_BITS   = 28;
  localparam int DIV_STAGES = DIV_BITS / 2;
  localparam int LAT        = DIV_STAGES + 8;

  localparam logic [31:0] CANON_NAN = 32'h7FC0_0000;

  typedef struct packed {
    logic [31:0] origin_x;
    logic [31:0] origin_y;
    logic [31:0] origin_z;
    logic [31:0] dir_x;
    logic [31:0] dir_y;
    logic [31:0] dir_z;
    logic [31:0] box_min_x;
    logic [31:0] box_min_y;
    logic [31:0] box_min_z;
    logic [31:0] box_max_x;
    logic [31:0] box_max_y;
    logic [31:0] box_max_z;
  } rbs_req_t;

  typedef struct packed {
    logic        hit;
    logic [31:0] t_near;
    logic [31:0] t_far;
  } rbs_rsp_t;

  // unrounded value: m/2^26 * 2^(e-127), m[26] set when finite nonzero
  typedef struct packed {
    logic               nan;
    logic               inf;
    logic               zero;
    logic               sgn;
    logic signed [11:0] e;
    logic [26:0]        m;
  } fp_unr_t;

  typedef struct packed {
    logic        nan;
    logic        inf;
    logic        zero;
    logic        sgn;
    logic        sub;
    logic [7:0]  e;
    logic [26:0] ma;
    logic [26:0] mb;
  } sub_al_t;

  typedef struct packed {
    logic               nan;
    logic               inf;
    logic               zero;
    logic               sgn;
    logic signed [11:0] e;
    logic [47:0]        p;
  } mul_p_t;

  typedef struct packed {
    logic               nan;
    logic               inf;
    logic               zero;
    logic               sgn;
    logic signed [11:0] e;
    logic [23:0]        m;
  } rcp_t;

  typedef struct packed {
    rcp_t        x;
    logic [24:0] r;
    logic [27:0] q;
  } div_t;

  typedef struct packed {
    logic        miss;
    logic [31:0] tn;
    logic [31:0] tf;
  } nar_t;

  function automatic logic is_nan(input logic [31:0] a);
    return (a[30:23] == 8'hFF) && (a[22:0] != 23'h0);
  endfunction

  function automatic logic is_inf(input logic [31:0] a);
    return (a[30:23] == 8'hFF) && (a[22:0] == 23'h0);
  endfunction

  function automatic logic [31:0] canon(input logic [31:0] a);
    return is_nan(a) ? CANON_NAN : a;
  endfunction

  function automatic logic [4:0] lzc24(input logic [23:0] m);
    logic [4:0] n;
    n = 5'd0;
    for (int i = 0; i < 24; i++) if (m[i]) n = 5'(23 - i);
    return n;
  endfunction

  function automatic logic [4:0] lzc27(input logic [26:0] m);
    logic [4:0] n;
    n = 5'd0;
    for (int i = 0; i < 27; i++) if (m[i]) n = 5'(26 - i);
    return n;
  endfunction

  function automatic logic [5:0] lzc48(input logic [47:0] m);
    logic [5:0] n;
    n = 6'd0;
    for (int i = 0; i < 48; i++) if (m[i]) n = 6'(47 - i);
    return n;
  endfunction

  function automatic logic [26:0] shr_sticky27(input logic [26:0] m, input logic [7:0] d);
    logic [26:0] sh;
    logic [26:0] mask;
    if (d >= 8'd27) return {26'h0, |m};
    sh   = m >> d;
    mask = ~(27'h7FF_FFFF << d);
    return sh | {26'h0, |(m & mask)};
  endfunction

  function automatic logic [31:0] fp_round(input fp_unr_t u);
    logic signed [11:0] ee;
    logic signed [11:0] sh;
    logic [26:0]        md;
    logic [7:0]         ef;
    logic [30:0]        pk;
    logic               inc;
    ee = u.e;
    if (u.nan) return CANON_NAN;
    if (u.inf) return {u.sgn, 8'hFF, 23'h0};
    if (u.zero) return {u.sgn, 31'h0};
    if (ee >= 12'sd255) return {u.sgn, 8'hFF, 23'h0};
    if (ee <= 12'sd0) begin
      sh = 12'sd1 - ee;
      md = shr_sticky27(u.m, sh[7:0]);
      ef = 8'h0;
    end else begin
      md = u.m;
      ef = ee[7:0];
    end
    pk  = {ef, md[25:3]};
    inc = md[2] & (md[3] | md[1] | md[0]);
    return {u.sgn, pk + {30'h0, inc}};
  endfunction

  // a - b, operand swap and alignment
  function automatic sub_al_t fsub_align(input logic [31:0] a, input logic [31:0] b);
    sub_al_t     r;
    logic [31:0] bn;
    logic [31:0] big;
    logic [31:0] sml;
    logic [7:0]  eg;
    logic [7:0]  es;
    logic        ai;
    logic        bi;
    logic        az;
    logic        bz;
    bn = {~b[31], b[30:0]};
    ai = is_inf(a);
    bi = is_inf(bn);
    az = (a[30:0] == 31'h0);
    bz = (bn[30:0] == 31'h0);
    if (a[30:0] >= bn[30:0]) begin
      big = a;
      sml = bn;
    end else begin
      big = bn;
      sml = a;
    end
    eg = (big[30:23] == 8'h0) ? 8'd1 : big[30:23];
    es = (sml[30:23] == 8'h0) ? 8'd1 : sml[30:23];
    r.nan  = is_nan(a) | is_nan(bn) | (ai & bi & (a[31] ^ bn[31]));
    r.inf  = ai | bi;
    r.zero = az & bz;
    if (ai) r.sgn = a[31];
    else if (bi) r.sgn = bn[31];
    else if (az & bz) r.sgn = a[31] & bn[31];
    else r.sgn = big[31];
    r.sub = big[31] ^ sml[31];
    r.e   = eg;
    r.ma  = {(big[30:23] != 8'h0), big[22:0], 3'b000};
    r.mb  = shr_sticky27({(sml[30:23] != 8'h0), sml[22:0], 3'b000}, eg - es);
    return r;
  endfunction

  function automatic fp_unr_t fsub_norm(input sub_al_t s);
    fp_unr_t     u;
    logic [27:0] sum;
    logic [4:0]  lz;
    u.nan  = s.nan;
    u.inf  = s.inf;
    u.zero = s.zero;
    u.sgn  = s.sgn;
    u.e    = 12'sd0;
    u.m    = 27'h0;
    sum = s.sub ? ({1'b0, s.ma} - {1'b0, s.mb}) : ({1'b0, s.ma} + {1'b0, s.mb});
    lz  = lzc27(sum[26:0]);
    if (!s.nan && !s.inf && !s.zero) begin
      if (sum == 28'h0) begin
        u.zero = 1'b1;
        u.sgn  = 1'b0;
      end else if (sum[27]) begin
        u.m = sum[27:1] | {26'h0, sum[0]};
        u.e = $signed({4'h0, s.e}) + 12'sd1;
      end else begin
        u.m = sum[26:0] << lz;
        u.e = $signed({4'h0, s.e}) - $signed({7'h0, lz});
      end
    end
    return u;
  endfunction

  function automatic mul_p_t fmul_pre(input logic [31:0] a, input logic [31:0] b);
    mul_p_t     r;
    logic [7:0] ea;
    logic [7:0] eb;
    logic       az;
    logic       bz;
    az = (a[30:0] == 31'h0);
    bz = (b[30:0] == 31'h0);
    ea = (a[30:23] == 8'h0) ? 8'd1 : a[30:23];
    eb = (b[30:23] == 8'h0) ? 8'd1 : b[30:23];
    r.nan  = is_nan(a) | is_nan(b) | (is_inf(a) & bz) | (az & is_inf(b));
    r.inf  = is_inf(a) | is_inf(b);
    r.zero = az | bz;
    r.sgn  = a[31] ^ b[31];
    r.e    = $signed({4'h0, ea}) + $signed({4'h0, eb}) - 12'sd127;
    r.p    = {24'h0, (a[30:23] != 8'h0), a[22:0]} * {24'h0, (b[30:23] != 8'h0), b[22:0]};
    return r;
  endfunction

  function automatic fp_unr_t fmul_norm(input mul_p_t p);
    fp_unr_t     u;
    logic [5:0]  lz;
    logic [47:0] pn;
    lz = lzc48(p.p);
    pn = p.p << lz;
    u.nan  = p.nan;
    u.inf  = p.inf;
    u.zero = p.zero;
    u.sgn  = p.sgn;
    u.m    = pn[47:21] | {26'h0, |pn[20:0]};
    u.e    = p.e + 12'sd1 - $signed({6'h0, lz});
    return u;
  endfunction

  function automatic div_t frcp_pre(input logic [31:0] d);
    div_t       v;
    logic [4:0] lz;
    logic [23:0] mt;
    mt = {(d[30:23] != 8'h0), d[22:0]};
    lz = lzc24(mt);
    v.x.nan  = is_nan(d);
    v.x.inf  = (d[30:0] == 31'h0);
    v.x.zero = is_inf(d);
    v.x.sgn  = d[31];
    v.x.m    = mt << lz;
    v.x.e    = $signed({4'h0, ((d[30:23] == 8'h0) ? 8'd1 : d[30:23])})
             - $signed({7'h0, lz});
    v.r      = 25'h080_0000;
    v.q      = 28'h0;
    return v;
  endfunction

  // two restoring quotient bits of 1.0 / m
  function automatic div_t div_step2(input div_t v);
    div_t o;
    o = v;
    for (int k = 0; k < 2; k++) begin
      if (o.r >= {1'b0, o.x.m}) begin
        o.r = o.r - {1'b0, o.x.m};
        o.q = {o.q[26:0], 1'b1};
      end else begin
        o.q = {o.q[26:0], 1'b0};
      end
      o.r = o.r << 1;
    end
    return o;
  endfunction

  function automatic logic [31:0] frcp_fin(input div_t v);
    fp_unr_t u;
    logic    st;
    st     = |v.r;
    u.nan  = v.x.nan;
    u.inf  = v.x.inf;
    u.zero = v.x.zero;
    u.sgn  = v.x.sgn;
    if (v.q[27]) begin
      u.m = v.q[27:1] | {26'h0, v.q[0] | st};
      u.e = 12'sd254 - v.x.e;
    end else begin
      u.m = v.q[26:0] | {26'h0, st};
      u.e = 12'sd253 - v.x.e;
    end
    return fp_round(u);
  endfunction

  // IEEE a < b, false on NaN
  function automatic logic flt(input logic [31:0] a, input logic [31:0] b);
    if (is_nan(a) || is_nan(b)) return 1'b0;
    if ((a[30:0] == 31'h0) && (b[30:0] == 31'h0)) return 1'b0;
    if (a[31] != b[31]) return a[31];
    if (!a[31]) return a[30:0] < b[30:0];
    return a[30:0] > b[30:0];
  endfunction

  function automatic nar_t narrow(input nar_t s, input logic [31:0] lo, input logic [31:0] hi);
    nar_t o;
    o = s;
    if (!s.miss) begin
      if (flt(hi, s.tn) || flt(s.tf, lo)) begin
        o.miss = 1'b1;
      end else begin
        if (flt(s.tn, lo)) o.tn = lo;
        if (flt(hi, s.tf)) o.tf = hi;
      end
    end
    return o;
  endfunction

endpackage

>>> design/ray_box_slab_test.sv
// ============================================================================
// ray_box_slab_test: pipelined ray versus axis-aligned box slab test
// Reciprocal, slab distances and interval narrowing in single precision.
// ============================================================================
// Usage:
//   A request (ray origin, direction, box corners) is taken at each rising
//   edge with start_i high and busy_o low. busy_o is always low: the
//   pipeline takes one request every cycle.
//   The result (hit, t_near, t_far) shows on res_o for one cycle with
//   done_o high; results leave in request order.
//   The reciprocal divider produces 28 quotient bits, two per stage; it is
//   followed by reciprocal rounding, multiply and three compare stages, and the subtract runs beside it.
//   Throughput is one request per cycle.
//   Reset clears all valid bits; requests in flight are dropped.
//   The receiver cannot stall, so nothing is held back.
//   A miss reports zero distances; NaN distances are sent as 0x7FC00000.
// ============================================================================
module ray_box_slab_test (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  rbs_pkg::rbs_req_t req_i,
  output logic              busy_o,
  output logic              done_o,
  output rbs_pkg::rbs_rsp_t res_o
);

  localparam int DS  = rbs_pkg::DIV_STAGES;
  localparam int LAT = rbs_pkg::LAT;

  logic [LAT-1:0] vld_q;

  logic [31:0] org [3];
  logic [31:0] dir [3];
  logic [31:0] bmn [3];
  logic [31:0] bmx [3];

  rbs_pkg::sub_al_t         sa_q [3][2];
  rbs_pkg::fp_unr_t         sn_q [3][2];
  logic [2:0][1:0][31:0]    df_q [DS];
  rbs_pkg::div_t            dv_q [DS+1][3];
  logic [31:0]              rd_q [3];
  rbs_pkg::mul_p_t          mp_q [3][2];
  rbs_pkg::fp_unr_t         mn_q [3][2];
  logic [31:0]              t_q  [3][2];
  logic [31:0]              lo_q [3];
  logic [31:0]              hi_q [3];
  rbs_pkg::nar_t            n1_q;
  logic [31:0]              lo2_q;
  logic [31:0]              hi2_q;
  rbs_pkg::rbs_rsp_t        res_q;
  rbs_pkg::nar_t            n2;
  rbs_pkg::nar_t            n0;

  assign busy_o = 1'b0;

  assign org[0] = req_i.origin_x;
  assign org[1] = req_i.origin_y;
  assign org[2] = req_i.origin_z;
  assign dir[0] = req_i.dir_x;
  assign dir[1] = req_i.dir_y;
  assign dir[2] = req_i.dir_z;
  assign bmn[0] = req_i.box_min_x;
  assign bmn[1] = req_i.box_min_y;
  assign bmn[2] = req_i.box_min_z;
  assign bmx[0] = req_i.box_max_x;
  assign bmx[1] = req_i.box_max_y;
  assign bmx[2] = req_i.box_max_z;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[LAT-2:0], start_i & ~busy_o};
    end
  end

  // subtract: align, normalize, round
  always_ff @(posedge clk_i) begin
    for (int ax = 0; ax < 3; ax++) begin
      sa_q[ax][0] <= rbs_pkg::fsub_align(bmn[ax], org[ax]);
      sa_q[ax][1] <= rbs_pkg::fsub_align(bmx[ax], org[ax]);
      for (int j = 0; j < 2; j++) begin
        sn_q[ax][j]     <= rbs_pkg::fsub_norm(sa_q[ax][j]);
        df_q[0][ax][j]  <= rbs_pkg::fp_round(sn_q[ax][j]);
      end
    end
    for (int k = 1; k < DS; k++) begin
      df_q[k] <= df_q[k-1];
    end
  end

  // reciprocal: normalize, divide, round
  always_ff @(posedge clk_i) begin
    for (int ax = 0; ax < 3; ax++) begin
      dv_q[0][ax] <= rbs_pkg::frcp_pre(dir[ax]);
      for (int k = 0; k < DS; k++) begin
        dv_q[k+1][ax] <= rbs_pkg::div_step2(dv_q[k][ax]);
      end
      rd_q[ax] <= rbs_pkg::frcp_fin(dv_q[DS][ax]);
    end
  end

  // slab distances and per-axis interval
  always_ff @(posedge clk_i) begin
    for (int ax = 0; ax < 3; ax++) begin
      for (int j = 0; j < 2; j++) begin
        mp_q[ax][j] <= rbs_pkg::fmul_pre(df_q[DS-1][ax][j], rd_q[ax]);
        mn_q[ax][j] <= rbs_pkg::fmul_norm(mp_q[ax][j]);
        t_q[ax][j]  <= rbs_pkg::fp_round(mn_q[ax][j]);
      end
      lo_q[ax] <= rbs_pkg::flt(t_q[ax][0], t_q[ax][1]) ? t_q[ax][0] : t_q[ax][1];
      hi_q[ax] <= rbs_pkg::flt(t_q[ax][1], t_q[ax][0]) ? t_q[ax][0] : t_q[ax][1];
    end
  end

  always_comb begin
    n0.miss = 1'b0;
    n0.tn   = lo_q[0];
    n0.tf   = hi_q[0];
    n2      = rbs_pkg::narrow(n1_q, lo2_q, hi2_q);
  end

  always_ff @(posedge clk_i) begin
    n1_q         <= rbs_pkg::narrow(n0, lo_q[1], hi_q[1]);
    lo2_q        <= lo_q[2];
    hi2_q        <= hi_q[2];
    res_q.hit    <= ~n2.miss;
    res_q.t_near <= n2.miss ? 32'h0 : rbs_pkg::canon(n2.tn);
    res_q.t_far  <= n2.miss ? 32'h0 : rbs_pkg::canon(n2.tf);
  end

  assign done_o = vld_q[LAT-1];
  assign res_o  = res_q;

endmodule

>>> design/rbs_chk.sv
// ============================================================================
// rbs_chk: port-level checks for the ray/box slab test
// Fixed latency, request/result pairing and result encoding rules.
// ============================================================================
module rbs_chk (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              start_i,
  input logic              busy_o,
  input logic              done_o,
  input rbs_pkg::rbs_rsp_t res_o
);

  a_lat_fwd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##(rbs_pkg::LAT) done_o)
    else $error("request without result");

  a_lat_bwd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i && !busy_o, rbs_pkg::LAT))
    else $error("result without request");

  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !res_o.hit) |-> (res_o.t_near == 32'h0) && (res_o.t_far == 32'h0))
    else $error("miss with nonzero distances");

  a_nan_canon: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !(rbs_pkg::is_nan(res_o.t_near) && (res_o.t_near != rbs_pkg::CANON_NAN))
            && !(rbs_pkg::is_nan(res_o.t_far) && (res_o.t_far != rbs_pkg::CANON_NAN)))
    else $error("non-canonical NaN");

endmodule

bind ray_box_slab_test rbs_chk u_rbs_chk (.*);

>>> tb/sv/tb_ray_box_slab_test.sv
// ============================================================================
// tb_ray_box_slab_test: self-checking bench for the ray/box slab test
// Drives directed ray/box rows, then random requests in bursts, predicts
// each result with an exact single-precision model of the slab test (or a
// preset result for fixed rows), and checks every result.
module tb_ray_box_slab_test;

  localparam int N_RANDOM  = 900;
  localparam int MAX_CYCLE = 200000;
  localparam logic [31:0] QNAN = 32'h7FC0_0000;

  typedef struct {
    rbs_pkg::rbs_req_t req;
    bit                fixed;
    rbs_pkg::rbs_rsp_t rsp;
  } slab_row_t;

  logic              clk_i;
  logic              rst_ni;
  logic              start_i;
  rbs_pkg::rbs_req_t req_i;
  logic              busy_o;
  logic              done_o;
  rbs_pkg::rbs_rsp_t res_o;

  bit                row_fixed;
  rbs_pkg::rbs_rsp_t row_rsp;

  rbs_pkg::rbs_rsp_t slab_expected_q[$];
  int                n_errors;
  int                n_requests;
  int                n_results;
  int                n_hits;
  int                cycle_cnt;
  slab_row_t         rows[$];

  ray_box_slab_test u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .req_i  (req_i),
    .busy_o (busy_o),
    .done_o (done_o),
    .res_o  (res_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // ---- exact single-precision arithmetic, round to nearest even ----
  function automatic bit f_nan(logic [31:0] a);
    return (a[30:23] == 8'hFF) && (a[22:0] != 0);
  endfunction

  function automatic bit f_inf(logic [31:0] a);
    return (a[30:23] == 8'hFF) && (a[22:0] == 0);
  endfunction

  function automatic logic [23:0] f_mant(logic [31:0] a);
    return {(a[30:23] != 0), a[22:0]};
  endfunction

  function automatic int f_exp(logic [31:0] a);
    return (a[30:23] == 0) ? 1 : int'(a[30:23]);
  endfunction

  // value = mag * 2^lsb
  function automatic logic [31:0] round_pack(bit sgn, logic [299:0] mag, int lsb);
    int           p;
    int           ex;
    int           rl;
    int           sh;
    logic [299:0] m;
    bit           g;
    bit           st;
    if (mag == 0) return {sgn, 31'h0};
    p = 0;
    for (int i = 0; i < 300; i++) if (mag[i]) p = i;
    ex = p + lsb;
    if (ex > 127) return {sgn, 8'hFF, 23'h0};
    rl = (ex >= -126) ? ex - 23 : -149;
    sh = rl - lsb;
    if (sh <= 0) begin
      m  = mag << (-sh);
      g  = 1'b0;
      st = 1'b0;
    end else begin
      m  = mag >> sh;
      g  = mag[sh-1];
      st = |(mag & ((300'b1 << (sh - 1)) - 300'b1));
    end
    if (g && (st || m[0])) m = m + 1;
    if (m[24]) begin
      m  = m >> 1;
      rl = rl + 1;
    end
    if (m[23] && (rl + 150 >= 255)) return {sgn, 8'hFF, 23'h0};
    return {sgn, (m[23] ? 8'(rl + 150) : 8'h0), m[22:0]};
  endfunction

  function automatic logic [31:0] fp_minus(logic [31:0] a, logic [31:0] b);
    logic [31:0]  bn;
    logic [299:0] va;
    logic [299:0] vb;
    bn = {~b[31], b[30:0]};
    if (f_nan(a) || f_nan(bn)) return QNAN;
    if (f_inf(a) && f_inf(bn)) return (a[31] != bn[31]) ? QNAN : a;
    if (f_inf(a)) return a;
    if (f_inf(bn)) return bn;
    va = 300'(f_mant(a)) << (f_exp(a) - 1);
    vb = 300'(f_mant(bn)) << (f_exp(bn) - 1);
    if (a[31] == bn[31]) return round_pack(a[31], va + vb, -149);
    if (va == vb) return {a[31] & bn[31], 31'h0};
    if (va > vb) return round_pack(a[31], va - vb, -149);
    return round_pack(bn[31], vb - va, -149);
  endfunction

  function automatic logic [31:0] fp_times(logic [31:0] a, logic [31:0] b);
    bit az;
    bit bz;
    bit s;
    az = (a[30:0] == 0);
    bz = (b[30:0] == 0);
    s  = a[31] ^ b[31];
    if (f_nan(a) || f_nan(b)) return QNAN;
    if ((f_inf(a) && bz) || (az && f_inf(b))) return QNAN;
    if (f_inf(a) || f_inf(b)) return {s, 8'hFF, 23'h0};
    return round_pack(s, 300'(48'(f_mant(a)) * 48'(f_mant(b))),
                      f_exp(a) + f_exp(b) - 300);
  endfunction

  function automatic logic [31:0] fp_inverse(logic [31:0] d);
    logic [63:0] num;
    logic [63:0] q;
    logic [63:0] rem;
    if (f_nan(d)) return QNAN;
    if (d[30:0] == 0) return {d[31], 8'hFF, 23'h0};
    if (f_inf(d)) return {d[31], 31'h0};
    num = 64'h1 << 60;
    q   = num / 64'(f_mant(d));
    rem = num % 64'(f_mant(d));
    return round_pack(d[31], {235'h0, q, (rem != 0)}, 150 - f_exp(d) - 61);
  endfunction

  function automatic bit fp_less(logic [31:0] a, logic [31:0] b);
    longint ka;
    longint kb;
    if (f_nan(a) || f_nan(b)) return 1'b0;
    ka = a[31] ? -longint'(a[30:0]) : longint'(a[30:0]);
    kb = b[31] ? -longint'(b[30:0]) : longint'(b[30:0]);
    return ka < kb;
  endfunction

  function automatic rbs_pkg::rbs_rsp_t slab_hit(rbs_pkg::rbs_req_t r);
    logic [31:0]       org[3];
    logic [31:0]       dir[3];
    logic [31:0]       bmn[3];
    logic [31:0]       bmx[3];
    logic [31:0]       lo[3];
    logic [31:0]       hi[3];
    logic [31:0]       t1;
    logic [31:0]       t2;
    logic [31:0]       rd;
    logic [31:0]       tn;
    logic [31:0]       tf;
    rbs_pkg::rbs_rsp_t o;
    org = '{r.origin_x, r.origin_y, r.origin_z};
    dir = '{r.dir_x, r.dir_y, r.dir_z};
    bmn = '{r.box_min_x, r.box_min_y, r.box_min_z};
    bmx = '{r.box_max_x, r.box_max_y, r.box_max_z};
    for (int ax = 0; ax < 3; ax++) begin
      rd = fp_inverse(dir[ax]);
      t1 = fp_times(fp_minus(bmn[ax], org[ax]), rd);
      t2 = fp_times(fp_minus(bmx[ax], org[ax]), rd);
      lo[ax] = fp_less(t1, t2) ? t1 : t2;
      hi[ax] = fp_less(t2, t1) ? t1 : t2;
    end
    tn = lo[0];
    tf = hi[0];
    o  = '0;
    for (int ax = 1; ax < 3; ax++) begin
      if (fp_less(hi[ax], tn) || fp_less(tf, lo[ax])) return o;
      if (fp_less(tn, lo[ax])) tn = lo[ax];
      if (fp_less(hi[ax], tf)) tf = hi[ax];
    end
    o.hit    = 1'b1;
    o.t_near = f_nan(tn) ? QNAN : tn;
    o.t_far  = f_nan(tf) ? QNAN : tf;
    return o;
  endfunction

  // ---- stimulus ----
  function automatic logic [31:0] rand_float(int emin, int emax);
    logic [31:0] m;
    m = $urandom;
    return {1'($urandom_range(0, 1)), 8'($urandom_range(emin, emax)), m[22:0]};
  endfunction

  function automatic logic [31:0] rand_special();
    logic [31:0] pool[10];
    pool = '{32'h0, 32'h8000_0000, 32'h7F80_0000, 32'hFF80_0000, 32'h7FC0_0000,
             32'hFFFF_FFFF, 32'h0000_0001, 32'h807F_FFFF, 32'h7F7F_FFFF, 32'h3F80_0000};
    return pool[$urandom_range(0, 9)];
  endfunction

  function automatic rbs_pkg::rbs_req_t rand_ray();
    logic [31:0]       f[12];
    logic [31:0]       a;
    logic [31:0]       b;
    int                kind;
    rbs_pkg::rbs_req_t r;
    kind = $urandom_range(0, 99);
    for (int i = 0; i < 12; i++) f[i] = $urandom;
    if (kind < 70) begin
      for (int ax = 0; ax < 3; ax++) begin
        f[ax]     = rand_float(118, 131);
        f[3 + ax] = ($urandom_range(0, 15) == 0) ? {1'($urandom_range(0, 1)), 31'h0}
                                                 : rand_float(105, 135);
        a = rand_float(118, 132);
        b = rand_float(118, 132);
        f[6 + ax] = fp_less(b, a) ? b : a;
        f[9 + ax] = fp_less(b, a) ? a : b;
      end
    end else if (kind < 85) begin
      for (int i = 0; i < 12; i++) if ($urandom_range(0, 2) == 0) f[i] = rand_special();
    end
    r = {f[0], f[1], f[2], f[3], f[4], f[5], f[6], f[7], f[8], f[9], f[10], f[11]};
    return r;
  endfunction

  function automatic void add_row(logic [31:0] o[3], logic [31:0] d[3], logic [31:0] lo[3],
                                  logic [31:0] hi[3], bit fixed, rbs_pkg::rbs_rsp_t rsp);
    slab_row_t w;
    w.req   = {o[0], o[1], o[2], d[0], d[1], d[2], lo[0], lo[1], lo[2], hi[0], hi[1], hi[2]};
    w.fixed = fixed;
    w.rsp   = rsp;
    rows.push_back(w);
  endfunction

  function automatic void build_rows();
    logic [31:0] z3[3];
    logic [31:0] one3[3];
    logic [31:0] two3[3];
    slab_row_t   w;
    z3   = '{32'h0, 32'h0, 32'h0};
    one3 = '{32'h3F80_0000, 32'h3F80_0000, 32'h3F80_0000};
    two3 = '{32'h4000_0000, 32'h4000_0000, 32'h4000_0000};
    add_row(z3, one3, one3, two3, 1, '{1'b1, 32'h3F80_0000, 32'h4000_0000});
    add_row(z3, one3, one3, '{32'h4000_0000, 32'h40C0_0000, 32'h4000_0000}, 0, '0);
    add_row(z3, one3, '{32'h3F80_0000, 32'h40A0_0000, 32'h3F80_0000},
            '{32'h4000_0000, 32'h40C0_0000, 32'h4000_0000}, 1, '0);
    add_row(z3, '{32'h0, 32'h3F80_0000, 32'h3F80_0000}, '{32'hBF80_0000, 32'h3F80_0000,
            32'h3F80_0000}, '{32'h3F80_0000, 32'h4000_0000, 32'h4000_0000},
            1, '{1'b1, 32'h3F80_0000, 32'h4000_0000});
    add_row(z3, '{32'h8000_0000, 32'h3F80_0000, 32'h3F80_0000}, '{32'hBF80_0000,
            32'h3F80_0000, 32'h3F80_0000}, two3, 0, '0);
    add_row(z3, '{32'h0, 32'h3F80_0000, 32'h3F80_0000}, one3, two3, 1, '0);
    add_row(z3, '{32'hBF80_0000, 32'hBF80_0000, 32'hBF80_0000}, one3, two3,
            1, '{1'b1, 32'hC000_0000, 32'hBF80_0000});
    add_row('{32'h7FC0_0000, 32'h0, 32'h0}, one3, one3, two3, 0, '0);
    add_row(z3, '{32'hFFC0_0001, 32'h3F80_0000, 32'h3F80_0000}, one3, two3, 0, '0);
    add_row(one3, '{32'h0, 32'h3F80_0000, 32'h3F80_0000}, one3, two3, 0, '0);
    add_row(z3, '{32'h0000_0001, 32'h8000_0001, 32'h3F80_0000}, z3, one3, 0, '0);
    add_row(z3, '{32'h7F7F_FFFF, 32'hFF7F_FFFF, 32'h007F_FFFF}, one3, two3, 0, '0);
    add_row(z3, '{32'h7F80_0000, 32'hFF80_0000, 32'h3F80_0000}, one3, two3, 0, '0);
    add_row(z3, one3, two3, one3, 0, '0);
    add_row('{32'hFF7F_FFFF, 32'h7F7F_FFFF, 32'h0}, one3, '{32'h7F7F_FFFF, 32'hFF7F_FFFF,
            32'h0}, '{32'h7F7F_FFFF, 32'h7F7F_FFFF, 32'h7F80_0000}, 0, '0);
    w.req = '0;
    w.fixed = 0;
    w.rsp = '0;
    rows.push_back(w);
    w.req = '1;
    rows.push_back(w);
  endfunction

  // ---- checking ----
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slab_expected_q.delete();
    end else begin
      cycle_cnt <= cycle_cnt + 1;
      if (done_o) begin
        if (slab_expected_q.size() == 0) begin
          $error("result with no request outstanding");
          n_errors++;
        end else begin
          rbs_pkg::rbs_rsp_t e;
          e = slab_expected_q.pop_front();
          if (res_o.hit !== e.hit) begin
            $error("hit: expected %0h actual %0h", e.hit, res_o.hit);
            n_errors++;
          end
          if (res_o.t_near !== e.t_near) begin
            $error("t_near: expected %08h actual %08h", e.t_near, res_o.t_near);
            n_errors++;
          end
          if (res_o.t_far !== e.t_far) begin
            $error("t_far: expected %08h actual %08h", e.t_far, res_o.t_far);
            n_errors++;
          end
          n_results++;
          if (e.hit) n_hits++;
        end
      end
      if (start_i && !busy_o) begin
        slab_expected_q.push_back(row_fixed ? row_rsp : slab_hit(req_i));
        n_requests++;
      end
    end
  end

  always @(posedge clk_i) begin
    if (cycle_cnt > MAX_CYCLE) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic send_req(rbs_pkg::rbs_req_t r, bit fixed, rbs_pkg::rbs_rsp_t rsp);
    start_i   <= 1'b1;
    req_i     <= r;
    row_fixed <= fixed;
    row_rsp   <= rsp;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
  endtask

  task automatic idle_gap(int n);
    if (n > 0) begin
      start_i <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  initial begin
    int burst;
    start_i   = 1'b0;
    req_i     = '0;
    row_fixed = 1'b0;
    row_rsp   = '0;
    n_errors  = 0;
    n_requests = 0;
    n_results = 0;
    n_hits    = 0;
    cycle_cnt = 0;
    rst_ni    = 1'b0;
    build_rows();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i]) begin
      send_req(rows[i].req, rows[i].fixed, rows[i].rsp);
      if ($urandom_range(0, 3) == 0) idle_gap($urandom_range(1, 3));
    end

    idle_gap(1);
    wait (slab_expected_q.size() == 0);
    @(posedge clk_i);

    burst = 0;
    for (int i = 0; i < N_RANDOM; i++) begin
      if (burst == 0) begin
        idle_gap(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8));
        burst = $urandom_range(1, 40);
      end
      if (i == N_RANDOM / 2) begin
        idle_gap(1);
        wait (slab_expected_q.size() == 0);
        @(posedge clk_i);
      end
      send_req(rand_ray(), 1'b0, '0);
      burst--;
    end
    start_i <= 1'b0;

    wait (slab_expected_q.size() == 0);
    repeat (rbs_pkg::LAT + 8) @(posedge clk_i);
    if (slab_expected_q.size() != 0) n_errors++;
    $display("%0d ray/box requests sent, %0d results checked, %0d hits",
             n_requests, n_results, n_hits);
    if (n_errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

>>> sim.f
design/rbs_pkg.sv
design/ray_box_slab_test.sv
design/rbs_chk.sv
tb/sv/tb_ray_box_slab_test.sv
